### src/txrb_pkg.sv
// Shared types and codes for the transmit ring buffer chunker.
package txrb_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Result kinds on the output channel.
  localparam logic RES_CHUNK = 1'b0;
  localparam logic RES_READ  = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_message;
    logic [7:0] read_offset;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] start_offset;
    logic [6:0] chunk_length;
    logic [7:0] read_data;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_byte;
    logic load_chunk;
    logic read_req;
    logic load_reply;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

### src/txrb_ctrl.sv
// Controller state machine of the transmit ring buffer chunker.
module txrb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          item_kind,
  input  logic                item_last,
  output logic                result_valid,
  input  logic                result_ready,
  input  txrb_pkg::dp_status_t status,
  output txrb_pkg::dp_cmd_t    cmd
);
  import txrb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;
  logic   busy;
  logic   busy_next;
  logic   dropping;
  logic   dropping_next;
  logic   accept;

  // Accept only when the result slot is free or is being emptied this cycle.
  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  always_comb begin
    cmd           = '0;
    busy_next     = busy;
    dropping_next = dropping;
    state_next    = state;
    if (state == S_READ) begin
      cmd.load_reply = 1'b1;
      state_next     = S_IDLE;
    end else if (accept) begin
      case (item_kind)
        KIND_ENQUEUE: begin
          if (dropping || status.full) begin
            // The marked last byte ends the dropped message.
            dropping_next = !item_last;
          end else begin
            cmd.store_byte = 1'b1;
            if (item_last && !busy) begin
              cmd.load_chunk = 1'b1;
              busy_next      = 1'b1;
            end
          end
        end
        KIND_DONE: begin
          busy_next = 1'b0;
          if (!status.empty) begin
            cmd.load_chunk = 1'b1;
            busy_next      = 1'b1;
          end
        end
        KIND_READ: begin
          cmd.read_req = 1'b1;
          state_next   = S_READ;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      dropping     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      busy     <= busy_next;
      dropping <= dropping_next;
      if (cmd.load_chunk || cmd.load_reply) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### src/txrb_dpath.sv
// Datapath of the transmit ring buffer chunker: pointers, byte store and result register.
module txrb_dpath #(
  parameter int BUFFER_DEPTH = 256,
  parameter int MAX_CHUNK    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  txrb_pkg::item_t      item,
  input  txrb_pkg::dp_cmd_t    cmd,
  output txrb_pkg::dp_status_t status,
  output txrb_pkg::result_t    result
);
  import txrb_pkg::*;

  localparam int PTR_W   = $clog2(BUFFER_DEPTH);
  localparam int RUN_MAX = (BUFFER_DEPTH > MAX_CHUNK) ? BUFFER_DEPTH : MAX_CHUNK;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);
  localparam int SUM_W   = RUN_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [RUN_W-1:0] DEPTH_R  = RUN_W'(BUFFER_DEPTH);
  localparam logic [RUN_W-1:0] MAX_R    = RUN_W'(MAX_CHUNK);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(BUFFER_DEPTH);

  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] wp_eff;
  logic [PTR_W-1:0] rp_adv;
  logic [RUN_W-1:0] span;
  logic [RUN_W-1:0] run;
  logic [SUM_W-1:0] rp_sum;
  logic [7:0]       byte_store [BUFFER_DEPTH];
  logic [7:0]       rd_byte;
  logic [PTR_W-1:0] mod_tab [256];

  // Read offsets wrap modulo the store depth; a constant table does the reduction.
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = PTR_W'(g % BUFFER_DEPTH);
  end

  assign wp_inc       = (write_pointer == LAST_PTR) ? '0 : write_pointer + 1'b1;
  assign status.full  = (wp_inc == read_pointer);
  assign status.empty = (write_pointer == read_pointer);

  // A chunk issued with the closing byte of a message sees the advanced pointer.
  assign wp_eff = cmd.store_byte ? wp_inc : write_pointer;

  always_comb begin
    if (read_pointer < wp_eff) begin
      span = RUN_W'(wp_eff) - RUN_W'(read_pointer);
    end else begin
      span = DEPTH_R - RUN_W'(read_pointer);
    end
    run    = (span > MAX_R) ? MAX_R : span;
    rp_sum = SUM_W'(read_pointer) + SUM_W'(run);
    rp_adv = (rp_sum == DEPTH_S) ? '0 : rp_sum[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
    end else begin
      if (cmd.store_byte) begin
        write_pointer <= wp_inc;
      end
      if (cmd.load_chunk) begin
        read_pointer <= rp_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      byte_store[write_pointer] <= item.data_byte;
    end
    if (cmd.read_req) begin
      rd_byte <= byte_store[mod_tab[item.read_offset]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_chunk) begin
      result.result_kind  <= RES_CHUNK;
      result.start_offset <= 8'(read_pointer);
      result.chunk_length <= 7'(run);
      result.read_data    <= '0;
    end else if (cmd.load_reply) begin
      result.result_kind  <= RES_READ;
      result.start_offset <= '0;
      result.chunk_length <= '0;
      result.read_data    <= rd_byte;
    end
  end

endmodule

### src/tx_ring_buffer_dma_chunker.sv
// Top level of the transmit ring buffer that hands out DMA chunks.
//
//   Channel   Direction  Handshake                    Payload
//   item      in         item_valid / item_ready      txrb_pkg::item_t
//   result    out        result_valid / result_ready  txrb_pkg::result_t
//
// For an enqueue or transfer-complete item, a chunk descriptor, if any,
// appears in the result register on the edge that accepts the item.
// A read item reads the store at the accepting edge; the reply is registered in S_READ,
// during which no item is taken.
// Reset (rst, synchronous) clears the pointers, busy, the drop flag and the result
// valid; the byte store is not cleared and needs no clearing pass.
// A new item is taken while the result register is empty or is being emptied in the
// same cycle, so a stalled result holds back the input.
module tx_ring_buffer_dma_chunker #(
  parameter int BUFFER_DEPTH = 256,
  parameter int MAX_CHUNK    = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  txrb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output txrb_pkg::result_t result
);
  import txrb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller owns the handshakes, busy and the drop flag of the current message.
  txrb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_kind    (item.kind),
    .item_last    (item.last_of_message),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath keeps the ring pointers, the byte store and the chunk arithmetic.
  txrb_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_CHUNK    (MAX_CHUNK)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
